[rtl/core/stack_machine_executor_assert.svh]
// ----------------------------------------------------------------------------
// Stack machine executor assertion macros
// Wraps concurrent assertions so that they can be compiled out as a group.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SME_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define SME_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SME_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SME_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/sme_pkg.sv]
// ----------------------------------------------------------------------------
// Stack machine executor package
// Opcodes, status codes, control states and the result record.
// ----------------------------------------------------------------------------
package sme_pkg;

  // Instruction opcodes.
  localparam logic [3:0] OP_PUSH   = 4'd0;
  localparam logic [3:0] OP_ADD    = 4'd1;
  localparam logic [3:0] OP_SUB    = 4'd2;
  localparam logic [3:0] OP_MUL    = 4'd3;
  localparam logic [3:0] OP_DIV    = 4'd4;
  localparam logic [3:0] OP_LT     = 4'd5;
  localparam logic [3:0] OP_GT     = 4'd6;
  localparam logic [3:0] OP_EQ     = 4'd7;
  localparam logic [3:0] OP_STORE  = 4'd8;
  localparam logic [3:0] OP_SETVAR = 4'd9;
  localparam logic [3:0] OP_LOAD   = 4'd10;
  localparam logic [3:0] OP_PRINT  = 4'd11;
  localparam logic [3:0] OP_JZ     = 4'd12;
  localparam logic [3:0] OP_JMP    = 4'd13;
  localparam logic [3:0] OP_HALT   = 4'd14;

  // Status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNSUP = 3'd1;
  localparam logic [2:0] ST_DIV0  = 3'd2;
  localparam logic [2:0] ST_OVER  = 3'd3;
  localparam logic [2:0] ST_UNDER = 3'd4;
  localparam logic [2:0] ST_UNDEF = 3'd5;

  localparam int IP_W = 13;

  // Control states of the sequencer.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_DIV    = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  // One result record.
  typedef struct packed {
    logic [IP_W-1:0] next_ip;
    logic            print_valid;
    logic [31:0]     print_value;
    logic            halted;
    logic [2:0]      status;
  } result_t;

endpackage

[rtl/core/stack_machine_executor.sv]
// ----------------------------------------------------------------------------
// Stack machine executor
// Executes one stack-machine instruction per request on an in-memory stack.
// ----------------------------------------------------------------------------
// Usage: an instruction request (opcode, operand, var_index) is taken on
// in_valid && in_ready; one result request (next_ip, print_valid,
// print_value, halted, status) is offered on out_valid until out_ready.
// Each instruction reads the two top stack entries and the variable slot in
// the cycle it is accepted; the registered memory data is used in the cycle
// after, in S_EXEC. The result is written back and the result request loaded
// at commit, in S_EXEC or, for multiply and divide, in S_COMMIT (a divide
// first waits in S_DIV for the one-bit-per-cycle divider).
// Reads and writes never overlap: the next request waits for the write-back.
// The output register lets a new request be accepted while a result waits;
// a stalled receiver holds the block only at the next write-back.
// After reset the stack and instruction pointer are zero and the variable
// store is cleared in a pass over all VAR_COUNT slots, during which in_ready
// is low.
// ----------------------------------------------------------------------------
`include "stack_machine_executor_assert.svh"

module stack_machine_executor #(
  parameter int STACK_DEPTH = 1024,
  parameter int VAR_COUNT   = 512,
  parameter int CODE_SIZE   = 8192
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         opcode,
  input  logic signed [31:0] operand,
  input  logic [8:0]         var_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [12:0]        next_ip,
  output logic               print_valid,
  output logic signed [31:0] print_value,
  output logic               halted,
  output logic [2:0]         status
);

  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int VW   = $clog2(VAR_COUNT);

  sme_pkg::state_t  state;
  sme_pkg::result_t res;
  sme_pkg::result_t out_q;

  logic [SP_W-1:0] sp;
  logic [SP_W-1:0] sp_next;
  logic [12:0]     ip;
  logic [3:0]      op_q;
  logic [31:0]     opnd_q;
  logic [VW-1:0]   vi_q;
  logic            vi_ok_q;
  logic [31:0]     rslt;

  logic            in_acc;
  logic            var_busy;
  logic [31:0]     a;
  logic [31:0]     b;
  logic [31:0]     var_rd;
  logic            var_def;
  logic [31:0]     alu;
  logic [31:0]     res_val;
  logic            long_op;
  logic            commit;
  logic            out_free;
  logic            stk_we;
  logic [AW-1:0]   stk_waddr;
  logic [31:0]     stk_wdata;
  logic            var_we;
  logic [12:0]     seq_ip;
  logic [12:0]     jmp_ip;
  logic            div_start;
  logic            div_done;
  logic [31:0]     quot;

  assign in_ready = (state == sme_pkg::S_IDLE) && !var_busy;
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Memories and the divider.
  sme_stack_ram #(.DEPTH(STACK_DEPTH), .AW(AW)) u_stack (
    .clk    (clk),
    .re     (in_acc),
    .raddr_a(AW'(sp - SP_W'(2))),
    .raddr_b(AW'(sp - SP_W'(1))),
    .rdata_a(a),
    .rdata_b(b),
    .we     (stk_we),
    .waddr  (stk_waddr),
    .wdata  (stk_wdata)
  );

  sme_var_ram #(.COUNT(VAR_COUNT), .VW(VW)) u_vars (
    .clk  (clk),
    .rst  (rst),
    .busy (var_busy),
    .re   (in_acc),
    .raddr(var_index[VW-1:0]),
    .rdata(var_rd),
    .rdef (var_def),
    .we   (var_we),
    .waddr(vi_q),
    .wdata(b)
  );

  sme_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(a),
    .divisor (b),
    .done    (div_done),
    .quotient(quot)
  );

  // Address arithmetic.
  always_comb begin
    seq_ip = ((14'(ip) + 14'd1) >= 14'(CODE_SIZE)) ? 13'd0 : 13'(ip + 13'd1);
    jmp_ip = (14'(opnd_q[12:0]) >= 14'(CODE_SIZE)) ? 13'd0 : opnd_q[12:0];
  end

  // Combinational arithmetic and compares.
  always_comb begin
    case (op_q)
      sme_pkg::OP_ADD: alu = a + b;
      sme_pkg::OP_SUB: alu = a - b;
      sme_pkg::OP_LT:  alu = {31'd0, $signed(a) < $signed(b)};
      sme_pkg::OP_GT:  alu = {31'd0, $signed(a) > $signed(b)};
      sme_pkg::OP_EQ:  alu = {31'd0, a == b};
      default:         alu = '0;
    endcase
  end

  assign long_op = (sp >= SP_W'(2)) &&
                   ((op_q == sme_pkg::OP_MUL) || ((op_q == sme_pkg::OP_DIV) && (b != '0)));
  assign res_val = (state == sme_pkg::S_COMMIT) ? rslt : alu;
  assign commit  = out_free &&
                   (((state == sme_pkg::S_EXEC) && !long_op) || (state == sme_pkg::S_COMMIT));
  assign div_start = (state == sme_pkg::S_EXEC) && long_op && (op_q == sme_pkg::OP_DIV);

  // Instruction decode and write-back values.
  always_comb begin
    sp_next         = sp;
    stk_we          = 1'b0;
    stk_waddr       = AW'(sp - SP_W'(2));
    stk_wdata       = res_val;
    var_we          = 1'b0;
    res.next_ip     = seq_ip;
    res.print_valid = 1'b0;
    res.print_value = '0;
    res.halted      = 1'b0;
    res.status      = sme_pkg::ST_OK;
    case (op_q)
      sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
      sme_pkg::OP_LT, sme_pkg::OP_GT, sme_pkg::OP_EQ: begin
        if (sp < SP_W'(2)) begin
          res.status = sme_pkg::ST_UNDER;
        end else begin
          stk_we  = commit;
          sp_next = SP_W'(sp - SP_W'(1));
          if ((op_q == sme_pkg::OP_DIV) && (b == '0)) begin
            res.status = sme_pkg::ST_DIV0;
          end
        end
      end
      sme_pkg::OP_PUSH, sme_pkg::OP_LOAD: begin
        stk_waddr = AW'(sp);
        if (op_q == sme_pkg::OP_PUSH) begin
          stk_wdata = opnd_q;
        end else if (vi_ok_q && var_def) begin
          stk_wdata = var_rd;
        end else begin
          stk_wdata  = '0;
          res.status = sme_pkg::ST_UNDEF;
        end
        if (sp >= SP_W'(STACK_DEPTH)) begin
          res.status = sme_pkg::ST_OVER;
        end else begin
          stk_we  = commit;
          sp_next = SP_W'(sp + SP_W'(1));
        end
      end
      sme_pkg::OP_STORE, sme_pkg::OP_SETVAR, sme_pkg::OP_PRINT, sme_pkg::OP_JZ: begin
        if (sp == '0) begin
          res.status = sme_pkg::ST_UNDER;
        end else begin
          sp_next = SP_W'(sp - SP_W'(1));
          if (op_q == sme_pkg::OP_PRINT) begin
            res.print_valid = 1'b1;
            res.print_value = b;
          end else if (op_q == sme_pkg::OP_JZ) begin
            if (b == '0) begin
              res.next_ip = jmp_ip;
            end
          end else if (vi_ok_q) begin
            var_we = commit;
          end else begin
            res.status = sme_pkg::ST_UNDEF;
          end
        end
      end
      sme_pkg::OP_JMP: begin
        res.next_ip = jmp_ip;
      end
      sme_pkg::OP_HALT: begin
        res.halted  = 1'b1;
        res.next_ip = ip;
      end
      default: begin
        res.halted  = 1'b1;
        res.next_ip = ip;
        res.status  = sme_pkg::ST_UNSUP;
      end
    endcase
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q    <= opcode;
      opnd_q  <= operand;
      vi_q    <= var_index[VW-1:0];
      vi_ok_q <= ({1'b0, var_index} < 10'(VAR_COUNT));
    end
  end

  // Long-operation result register, one register after the multiplier; it also holds the divider quotient.
  always_ff @(posedge clk) begin
    if ((state == sme_pkg::S_EXEC) && long_op && (op_q == sme_pkg::OP_MUL)) begin
      rslt <= 32'(a * b);
    end else if ((state == sme_pkg::S_DIV) && div_done) begin
      rslt <= quot;
    end
  end

  // Sequencer, stack pointer and instruction pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sme_pkg::S_IDLE;
      sp    <= '0;
      ip    <= '0;
    end else begin
      case (state)
        sme_pkg::S_IDLE: begin
          if (in_acc) begin
            state <= sme_pkg::S_EXEC;
          end
        end
        sme_pkg::S_EXEC: begin
          if (long_op) begin
            state <= (op_q == sme_pkg::OP_MUL) ? sme_pkg::S_COMMIT : sme_pkg::S_DIV;
          end else if (commit) begin
            state <= sme_pkg::S_IDLE;
          end
        end
        sme_pkg::S_DIV: begin
          if (div_done) begin
            state <= sme_pkg::S_COMMIT;
          end
        end
        sme_pkg::S_COMMIT: begin
          if (commit) begin
            state <= sme_pkg::S_IDLE;
          end
        end
        default: state <= sme_pkg::S_IDLE;
      endcase
      if (commit) begin
        sp <= sp_next;
        ip <= res.next_ip;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_q <= res;
    end
  end

  assign next_ip     = out_q.next_ip;
  assign print_valid = out_q.print_valid;
  assign print_value = out_q.print_value;
  assign halted      = out_q.halted;
  assign status      = out_q.status;

  // Checks on the sequencer, the stack and the output.
  `SME_ASSERT_IMP(a_sp_bound, clk, rst, 1'b1, sp <= SP_W'(STACK_DEPTH), "stack pointer above depth")
  `SME_ASSERT_NXT(a_accept_exec, clk, rst, in_acc, state == sme_pkg::S_EXEC, "accept did not start execution")
  `SME_ASSERT_NXT(a_halt_hold, clk, rst, commit && (op_q == sme_pkg::OP_HALT), ip == $past(ip), "halt moved the instruction pointer")
  `SME_ASSERT_IMP(a_print_zero, clk, rst, out_valid && !print_valid, print_value == '0, "print value without print")

endmodule

[rtl/core/sme_stack_ram.sv]
// ----------------------------------------------------------------------------
// Operand stack memory
// One write port and two registered read ports for the two top entries.
// ----------------------------------------------------------------------------
module sme_stack_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [31:0]   rdata_a,
  output logic [31:0]   rdata_b,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata
);

  logic [31:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports, data held until the next read request.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[rtl/core/sme_var_ram.sv]
// ----------------------------------------------------------------------------
// Variable store
// Value and defined mark per slot in one memory, cleared by a pass after reset.
// ----------------------------------------------------------------------------
module sme_var_ram #(
  parameter int COUNT = 512,
  parameter int VW    = 9
) (
  input  logic          clk,
  input  logic          rst,
  output logic          busy,
  input  logic          re,
  input  logic [VW-1:0] raddr,
  output logic [31:0]   rdata,
  output logic          rdef,
  input  logic          we,
  input  logic [VW-1:0] waddr,
  input  logic [31:0]   wdata
);

  logic [32:0]   mem [COUNT];
  logic [VW-1:0] clr_addr;
  logic          we_mux;
  logic [VW-1:0] addr_mux;
  logic [32:0]   data_mux;

  // Clearing pass walks every slot once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == VW'(COUNT - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= VW'(clr_addr + 1'b1);
    end
  end

  // Write port shared between the clearing pass and stores.
  always_comb begin
    we_mux   = busy | we;
    addr_mux = busy ? clr_addr : waddr;
    data_mux = busy ? 33'd0 : {1'b1, wdata};
  end

  always_ff @(posedge clk) begin
    if (we_mux) begin
      mem[addr_mux] <= data_mux;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    if (re) begin
      {rdef, rdata} <= mem[raddr];
    end
  end

endmodule

[rtl/core/sme_divider.sv]
// ----------------------------------------------------------------------------
// Signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module sme_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        run;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic [32:0] shifted;
  logic [32:0] diff;

  // One restoring step.
  always_comb begin
    shifted = {rem, quo[31]};
    diff    = shifted - {1'b0, dvs};
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd32;
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers work on magnitudes.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[31] ? 32'(-dividend) : dividend;
      dvs <= divisor[31] ? 32'(-divisor) : divisor;
      neg <= dividend[31] ^ divisor[31];
    end else if (run) begin
      rem <= diff[32] ? shifted[31:0] : diff[31:0];
      quo <= {quo[30:0], ~diff[32]};
    end
  end

  assign quotient = neg ? 32'(-quo) : quo;

endmodule
